### hw/rtl/ctcgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTC greedy decoder package
// Shared widths, defaults, register map, controller states and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam int MAX_CLASSES_DEF = 8192;
  localparam int MAX_STEPS_DEF   = 1024;

  localparam int CFG_W   = 14;
  localparam int SCORE_W = 16;
  localparam int IDX_W   = 13;
  localparam int CHAR_W  = 11;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 14'd8192;

  localparam logic [APB_AW-1:0] ADDR_CLASS_COUNT = 3'd0;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ctcgd_state_t;

  typedef struct packed {
    logic accept;
    logic load_div;
    logic div_step;
    logic emit_sum;
  } ctcgd_ctl_t;

  typedef struct packed {
    logic out_free;
    logic div_last;
  } ctcgd_sts_t;

endpackage
`default_nettype wire

### hw/rtl/ctcgd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTC greedy decoder channels
// Valid/ready word channels for score input and decoded output.
// ----------------------------------------------------------------------------
interface ctcgd_in_if
  import ctcgd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      end_of_sequence;

  modport source (output valid, score, end_of_sequence, input ready);
  modport sink   (input valid, score, end_of_sequence, output ready);
endinterface

interface ctcgd_out_if
  import ctcgd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      is_summary;
  logic [IDX_W-1:0]          class_index;
  logic signed [SCORE_W-1:0] class_score;
  logic signed [SCORE_W-1:0] confidence;
  logic [CHAR_W-1:0]         char_count;
  logic                      last;

  modport source (output valid, is_summary, class_index, class_score, confidence,
                  char_count, last, input ready);
  modport sink   (input valid, is_summary, class_index, class_score, confidence,
                  char_count, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/ctcgd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTC greedy decoder controller
// Sequences score intake, the end-of-sequence divide and the summary word.
// ----------------------------------------------------------------------------
module ctcgd_ctrl
  import ctcgd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_eos,
  output logic            in_ready,
  input  wire ctcgd_sts_t sts,
  output ctcgd_ctl_t      ctl
);

  ctcgd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_valid && sts.out_free && in_eos) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_ready   = sts.out_free;
        ctl.accept = in_valid && sts.out_free;
      end
      ST_LOAD: begin
        ctl.load_div = 1'b1;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
      end
      ST_EMIT: begin
        ctl.emit_sum = sts.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/ctcgd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTC greedy decoder datapath
// Running maximum, character emit, score sum, serial divider, output word.
// ----------------------------------------------------------------------------
module ctcgd_datapath
  import ctcgd_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [CFG_W-1:0]          class_count,
  input  wire logic signed [SCORE_W-1:0] score,
  input  wire logic                      eos,
  input  wire ctcgd_ctl_t                ctl,
  output ctcgd_sts_t                     sts,
  ctcgd_out_if.source                    out_if
);

  localparam int POS_W = (MAX_CLASSES > 8192) ? CFG_W : $clog2(MAX_CLASSES);
  localparam int SUM_W = SCORE_W + $clog2(MAX_STEPS);
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int IT_W  = $clog2(SUM_W);
  localparam int EFF_W = 17;

  logic [POS_W-1:0]          pos_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [POS_W-1:0]          best_class_r;
  logic [POS_W-1:0]          prev_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]          count_r;

  logic [SUM_W-1:0]          quo_r;
  logic [CNT_W-1:0]          rem_r;
  logic                      neg_r;
  logic [IT_W-1:0]           it_r;

  logic                      out_valid_r;
  logic                      is_summary_r;
  logic [IDX_W-1:0]          class_index_r;
  logic signed [SCORE_W-1:0] class_score_r;
  logic signed [SCORE_W-1:0] confidence_r;
  logic [CHAR_W-1:0]         char_count_r;

  logic [EFF_W-1:0]          eff;
  logic [EFF_W-1:0]          pos_inc;
  logic signed [SCORE_W-1:0] best_s;
  logic [POS_W-1:0]          best_c;
  logic                      close;
  logic                      emit;
  logic                      add;
  logic [CNT_W:0]            shifted;
  logic                      fits;
  logic [SCORE_W-1:0]        quo_lo;
  logic signed [SCORE_W-1:0] conf;

  // effective class count, clamped to [2, MAX_CLASSES]
  always_comb begin
    if (class_count < CFG_W'(2)) begin
      eff = EFF_W'(2);
    end else if (EFF_W'(class_count) > EFF_W'(MAX_CLASSES)) begin
      eff = EFF_W'(MAX_CLASSES);
    end else begin
      eff = EFF_W'(class_count);
    end
  end

  always_comb begin
    if (pos_r == '0) begin
      best_s = score;
      best_c = '0;
    end else if (score > best_score_r) begin
      best_s = score;
      best_c = pos_r;
    end else begin
      best_s = best_score_r;
      best_c = best_class_r;
    end
    pos_inc = EFF_W'(pos_r) + EFF_W'(1);
    close   = (pos_inc >= eff) || eos;
    emit    = close && (best_c != '0) && (best_c != prev_r);
    add     = emit && (count_r < CNT_W'(MAX_STEPS));
  end

  // restoring divide step on magnitudes
  always_comb begin
    shifted = {rem_r, quo_r[SUM_W-1]};
    fits    = shifted >= {1'b0, count_r};
    quo_lo  = quo_r[SCORE_W-1:0];
    if (count_r == '0) begin
      conf = '0;
    end else if (neg_r) begin
      conf = -$signed(quo_lo);
    end else begin
      conf = $signed(quo_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
      prev_r       <= '0;
      sum_r        <= '0;
      count_r      <= '0;
    end else if (ctl.accept) begin
      best_score_r <= eos ? '0 : best_s;
      best_class_r <= eos ? '0 : best_c;
      pos_r        <= close ? '0 : pos_inc[POS_W-1:0];
      if (close) prev_r <= eos ? '0 : best_c;
      if (add) begin
        sum_r   <= sum_r + SUM_W'(best_s);
        count_r <= count_r + CNT_W'(1);
      end
    end else if (ctl.emit_sum) begin
      sum_r   <= '0;
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_div) begin
      neg_r <= sum_r[SUM_W-1];
      quo_r <= sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
      rem_r <= '0;
      it_r  <= '0;
    end else if (ctl.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? CNT_W'(shifted - {1'b0, count_r}) : shifted[CNT_W-1:0];
      it_r  <= it_r + IT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctl.accept && emit) || ctl.emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && emit) begin
      is_summary_r  <= 1'b0;
      class_index_r <= IDX_W'(best_c);
      class_score_r <= best_s;
      confidence_r  <= '0;
      char_count_r  <= '0;
    end else if (ctl.emit_sum) begin
      is_summary_r  <= 1'b1;
      class_index_r <= '0;
      class_score_r <= '0;
      confidence_r  <= conf;
      char_count_r  <= CHAR_W'(count_r);
    end
  end

  assign sts.out_free = !out_valid_r || out_if.ready;
  assign sts.div_last = it_r == IT_W'(SUM_W - 1);

  assign out_if.valid       = out_valid_r;
  assign out_if.is_summary  = is_summary_r;
  assign out_if.class_index = class_index_r;
  assign out_if.class_score = class_score_r;
  assign out_if.confidence  = confidence_r;
  assign out_if.char_count  = char_count_r;
  assign out_if.last        = is_summary_r;

endmodule
`default_nettype wire

### hw/rtl/ctc_greedy_decoder.sv
`default_nettype none
// A character word is registered and appears in the cycle after the score that closes its step.
// Throughput: one score word per cycle while the output is drained and no divide is running.
// End of sequence: input stalls while the serial divider is loaded and run, and then until
// the summary word is emitted; only after that is the next score taken.
// Reset: synchronous, active low; clears sequence state and sets class_count to 8192.
// ----------------------------------------------------------------------------
// CTC greedy decoder
// Greedy best-path decode of streamed class scores with APB configuration.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder
  import ctcgd_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ctcgd_in_if.sink               in_if,
  ctcgd_out_if.source            out_if,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [CFG_W-1:0] class_count_r;
  logic             in_ready;
  ctcgd_ctl_t       ctl;
  ctcgd_sts_t       sts;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CLASS_COUNT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[APB_AW-1:2] == ADDR_CLASS_COUNT[APB_AW-1:2]) begin
      class_count_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[APB_AW-1:2])
      ADDR_CLASS_COUNT[APB_AW-1:2]: cfg_prdata = APB_DW'(class_count_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  assign in_if.ready = in_ready;

  ctcgd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_eos   (in_if.end_of_sequence),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ctcgd_datapath #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .class_count (class_count_r),
    .score       (in_if.score),
    .eos         (in_if.end_of_sequence),
    .ctl         (ctl),
    .sts         (sts),
    .out_if      (out_if)
  );

  a_eos_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_ready && in_if.end_of_sequence) |=> !in_ready)
    else $error("input taken right after end of sequence");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.accept, ctl.load_div, ctl.div_step, ctl.emit_sum}))
    else $error("conflicting datapath commands");

  a_summary_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_sum |-> sts.out_free)
    else $error("summary word overwrites pending output");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctl.emit_sum) |-> (out_if.valid && out_if.last && out_if.is_summary))
    else $error("summary word not presented");

endmodule
`default_nettype wire

### verif/tb_ctc_greedy_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CTC greedy decoder testbench
// Streams class scores into the decoder under random source and sink stalls,
// predicts every character and summary word from a behavioral decode of the
// same stream, and compares each output word in order. Covers class_count
// clamping, resizing inside a step, early end marks and a long random
// stretch over several class counts.
// ----------------------------------------------------------------------------
module tb_ctc_greedy_decoder
  import ctcgd_pkg::*;
;

  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic                      is_summary;
    logic [IDX_W-1:0]          class_index;
    logic signed [SCORE_W-1:0] class_score;
    logic signed [SCORE_W-1:0] confidence;
    logic [CHAR_W-1:0]         char_count;
    logic                      last;
  } dec_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  ctcgd_in_if  in_ch ();
  ctcgd_out_if out_ch ();

  ctc_greedy_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bit        src_idle_on;
  bit        snk_idle_on;
  int        errors;
  int        quiet_cycles;
  int        sent_scores;
  dec_word_t pending_words[$];

  logic [CFG_W-1:0]          cc_reg;
  int                        slot;
  logic signed [SCORE_W-1:0] lead_score;
  logic [IDX_W-1:0]          lead_class;
  logic [IDX_W-1:0]          prior_class;
  longint                    run_sum;
  int                        run_chars;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic int eff_count();
    if (cc_reg < 2) return 2;
    if (cc_reg > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
    return cc_reg;
  endfunction

  function automatic void clear_sequence();
    slot        = 0;
    lead_score  = '0;
    lead_class  = '0;
    prior_class = '0;
    run_sum     = 0;
    run_chars   = 0;
  endfunction

  function automatic void decode_score(logic signed [SCORE_W-1:0] sc, logic eos);
    dec_word_t w;
    longint    q;
    if (slot == 0) begin
      lead_score = sc;
      lead_class = '0;
    end else if (sc > lead_score) begin
      lead_score = sc;
      lead_class = slot[IDX_W-1:0];
    end
    slot++;
    if (slot >= eff_count() || eos) begin
      if (lead_class != 0 && lead_class != prior_class) begin
        w             = '0;
        w.class_index = lead_class;
        w.class_score = lead_score;
        pending_words.insert(pending_words.size(), w);
        if (run_chars < MAX_STEPS_DEF) begin
          run_sum += lead_score;
          run_chars++;
        end
      end
      prior_class = lead_class;
      slot        = 0;
    end
    if (eos) begin
      q            = (run_chars != 0) ? run_sum / longint'(run_chars) : 0;
      w            = '0;
      w.is_summary = 1'b1;
      w.confidence = q[SCORE_W-1:0];
      w.char_count = run_chars[CHAR_W-1:0];
      w.last       = 1'b1;
      pending_words.insert(pending_words.size(), w);
      clear_sequence();
    end
  endfunction

  function automatic logic signed [SCORE_W-1:0] draw_score();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    dec_word_t got;
    dec_word_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.is_summary  = out_ch.is_summary;
      got.class_index = out_ch.class_index;
      got.class_score = out_ch.class_score;
      got.confidence  = out_ch.confidence;
      got.char_count  = out_ch.char_count;
      got.last        = out_ch.last;
      if (pending_words.size() == 0) begin
        note_error($sformatf({"unexpected word sum=%0b idx=%0d score=%0d conf=%0d ",
                              "cnt=%0d last=%0b"},
                             got.is_summary, got.class_index, got.class_score,
                             got.confidence, got.char_count, got.last));
      end else begin
        exp = pending_words.pop_front();
        if (got !== exp)
          note_error($sformatf({"word mismatch exp sum=%0b idx=%0d score=%0d conf=%0d cnt=%0d ",
                                "last=%0b got sum=%0b idx=%0d score=%0d conf=%0d cnt=%0d last=%0b"},
                               exp.is_summary, exp.class_index, exp.class_score,
                               exp.confidence, exp.char_count, exp.last,
                               got.is_summary, got.class_index, got.class_score,
                               got.confidence, got.char_count, got.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_score(input logic signed [SCORE_W-1:0] sc, input logic eos);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid           = 1'b1;
    in_ch.score           = sc;
    in_ch.end_of_sequence = eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_score(sc, eos);
    sent_scores++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_class_count(input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    drain();
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_CLASS_COUNT;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cc_reg = value[CFG_W-1:0];
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (rd !== APB_DW'(cc_reg))
      note_error($sformatf("class_count readback exp=%0d got=%0d", cc_reg, rd));
  endtask

  task automatic send_sequence(input int steps, input bit broken);
    int lim;
    int cut;
    bit eos;
    lim = eff_count();
    for (int s = 0; s < steps; s++) begin
      cut = (broken && s == steps - 1) ? $urandom_range(0, lim - 1) : lim - 1;
      for (int k = 0; k <= cut; k++) begin
        eos = (s == steps - 1) && (k == cut);
        push_score(draw_score(), eos);
      end
    end
  endtask

  task automatic test_directed();
    logic signed [SCORE_W-1:0] seq[23] = '{
      -16'sd3, 16'sd4, 16'sd4, 16'sh8000,
      16'sd0, 16'sd7, 16'sd7, 16'sd3,
      16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
      -16'sd5, -16'sd5, -16'sd5, -16'sd5,
      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001,
      -16'sd1, 16'sd3,
      16'sd7
    };
    write_class_count(4);
    for (int k = 0; k < 23; k++)
      push_score(seq[k], k == 19 || k == 21 || k == 22);
  endtask

  task automatic test_count_clamp();
    write_class_count(0);
    send_sequence(3, 1'b0);
    write_class_count(1);
    send_sequence(2, 1'b0);
    write_class_count(16383);
    for (int k = 0; k < 5; k++)
      push_score(draw_score(), k == 4);
  endtask

  task automatic test_resize_mid_step();
    write_class_count(6);
    push_score(16'sd0, 1'b0);
    push_score(16'sd1, 1'b0);
    push_score(16'sd9, 1'b0);
    push_score(16'sd2, 1'b0);
    write_class_count(3);
    push_score(16'sd4, 1'b0);
    send_sequence(1, 1'b0);
  endtask

  task automatic test_random();
    int start;
    int n;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase >= 6) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end
      case (phase)
        0, 6:    write_class_count(2);
        1:       write_class_count(3);
        3:       write_class_count(5);
        4:       write_class_count(0);
        5:       write_class_count($urandom_range(4, 12));
        default: write_class_count($urandom_range(2, 20));
      endcase
      start = sent_scores;
      while (sent_scores - start < 90) begin
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(1, 12);
          for (int k = 0; k < n; k++)
            push_score(draw_score(), k == n - 1 || $urandom_range(0, 5) == 0);
        end else begin
          send_sequence($urandom_range(1, 6), $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.score           = '0;
    in_ch.end_of_sequence = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    src_idle_on           = 1'b1;
    snk_idle_on           = 1'b1;
    errors                = 0;
    quiet_cycles          = 0;
    sent_scores           = 0;
    cc_reg                = CLASS_COUNT_RST;
    clear_sequence();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_count_clamp();
    test_resize_mid_step();
    test_random();

    drain();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
